// File: hdl/tkc_pkg.sv
// Shared types and constants for the top-k-by-count selector.
// Used by tkc_ctrl, tkc_datapath and top_k_by_count_selector; no dependencies.
package tkc_pkg;

  // Field widths fixed by the record format
  localparam int DW = 32;
  localparam int KW = 5;

  // Reset value of the k register
  localparam logic [KW-1:0] K_RESET = 5'd16;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INSERT,
    OP_EVICT,
    OP_SHIFT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } tkc_cmd_t;

  typedef struct packed {
    logic over_k;     // more kept records than k allows
    logic last_pend;  // held record carries the last-item mark
    logic one_left;   // exactly one kept record remains
  } tkc_status_t;

endpackage

// File: hdl/tkc_ctrl.sv
// Sequencing controller for the top-k-by-count selector.
// Depends on tkc_pkg for the command and status types.
module tkc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tkc_pkg::tkc_status_t status,
  output tkc_pkg::tkc_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_TRIM,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Pick the datapath operation and the next state
  always_comb begin
    state_nxt = state_r;
    cmd.op    = tkc_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = tkc_pkg::OP_LOAD;
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        // shrink to a lowered k before taking the new record
        if (status.over_k) begin
          cmd.op = tkc_pkg::OP_EVICT;
        end else begin
          cmd.op    = tkc_pkg::OP_INSERT;
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (status.over_k) begin
          cmd.op = tkc_pkg::OP_EVICT;
        end else if (status.last_pend) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          cmd.op = tkc_pkg::OP_SHIFT;
          if (status.one_left) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule

// File: hdl/tkc_datapath.sv
// Sorted cell chain, held input record and k register of the selector.
// Depends on tkc_pkg for widths, reset value and command/status types.
module tkc_datapath #(
  parameter int MAX_K = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tkc_pkg::tkc_cmd_t          cmd,
  output tkc_pkg::tkc_status_t       status,
  input  logic                       cfg_we,
  input  logic [tkc_pkg::KW-1:0]     cfg_k_count,
  input  logic [tkc_pkg::DW-1:0]     in_location_id,
  input  logic [tkc_pkg::DW-1:0]     in_population,
  input  logic                       in_last_item,
  output logic [tkc_pkg::DW-1:0]     out_id,
  output logic [tkc_pkg::DW-1:0]     out_population,
  output logic                       out_last_result
);

  // One spare cell holds the record that overflows a full store
  localparam int NC = MAX_K + 1;
  localparam int CW = $clog2(MAX_K + 2);
  localparam int EW = (CW > tkc_pkg::KW) ? CW : tkc_pkg::KW;

  logic [tkc_pkg::DW-1:0] id_r  [NC];
  logic [tkc_pkg::DW-1:0] pop_r [NC];
  logic [tkc_pkg::DW-1:0] id_nxt  [NC];
  logic [tkc_pkg::DW-1:0] pop_nxt [NC];
  logic [NC-1:0]          vld;
  logic [NC-1:0]          ge;
  logic [NC-1:0]          eq;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;
  logic [tkc_pkg::KW-1:0] k_r;
  logic [tkc_pkg::DW-1:0] hid_r;
  logic [tkc_pkg::DW-1:0] hpop_r;
  logic                   hlast_r;
  logic [EW-1:0]          k_ext;
  logic [EW-1:0]          k_eff;

  // Clamp k to 1..MAX_K
  always_comb begin
    k_ext = EW'(k_r);
    if (k_ext == '0) begin
      k_eff = EW'(1);
    end else if (k_ext > EW'(MAX_K)) begin
      k_eff = EW'(MAX_K);
    end else begin
      k_eff = k_ext;
    end
  end

  // Per-cell compares against the held record and the head
  for (genvar g = 0; g < NC; g++) begin : g_cmp
    assign vld[g] = (CW'(g) < cnt_r);
    assign ge[g]  = vld[g] && (pop_r[g] <= hpop_r);
    assign eq[g]  = vld[g] && (pop_r[g] == pop_r[0]);
  end

  // Next value of each cell
  for (genvar g = 0; g < NC; g++) begin : g_cell
    logic           take_new;
    logic [tkc_pkg::DW-1:0] up_id;
    logic [tkc_pkg::DW-1:0] up_pop;
    logic [tkc_pkg::DW-1:0] dn_id;
    logic [tkc_pkg::DW-1:0] dn_pop;
    logic           keep_ev;

    if (g == 0) begin : g_first
      assign take_new = !ge[0];
      assign dn_id    = id_r[0];
      assign dn_pop   = pop_r[0];
    end else begin : g_rest
      assign take_new = !ge[g] && ge[g-1];
      assign dn_id    = id_r[g-1];
      assign dn_pop   = pop_r[g-1];
    end

    if (g == NC - 1) begin : g_tail
      assign up_id   = id_r[g];
      assign up_pop  = pop_r[g];
      assign keep_ev = 1'b1;
    end else begin : g_body
      assign up_id   = id_r[g+1];
      assign up_pop  = pop_r[g+1];
      assign keep_ev = eq[g+1];
    end

    always_comb begin
      id_nxt[g]  = id_r[g];
      pop_nxt[g] = pop_r[g];
      unique case (cmd.op)
        tkc_pkg::OP_INSERT: begin
          // keep smaller-or-equal entries, drop in the new one, push the rest up
          if (ge[g]) begin
            id_nxt[g]  = id_r[g];
            pop_nxt[g] = pop_r[g];
          end else if (take_new) begin
            id_nxt[g]  = hid_r;
            pop_nxt[g] = hpop_r;
          end else begin
            id_nxt[g]  = dn_id;
            pop_nxt[g] = dn_pop;
          end
        end
        tkc_pkg::OP_EVICT: begin
          // remove the latest arrival among the lowest populations
          if (!keep_ev) begin
            id_nxt[g]  = up_id;
            pop_nxt[g] = up_pop;
          end
        end
        tkc_pkg::OP_SHIFT: begin
          id_nxt[g]  = up_id;
          pop_nxt[g] = up_pop;
        end
        default: ;
      endcase
    end
  end

  // Fill count
  always_comb begin
    unique case (cmd.op)
      tkc_pkg::OP_INSERT: cnt_nxt = cnt_r + CW'(1);
      tkc_pkg::OP_EVICT,
      tkc_pkg::OP_SHIFT:  cnt_nxt = cnt_r - CW'(1);
      default:            cnt_nxt = cnt_r;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      k_r   <= tkc_pkg::K_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        k_r <= cfg_k_count;
      end
    end
  end

  // Advance the cells and capture the incoming record
  always_ff @(posedge clk) begin
    for (int i = 0; i < NC; i++) begin
      id_r[i]  <= id_nxt[i];
      pop_r[i] <= pop_nxt[i];
    end
    if (cmd.op == tkc_pkg::OP_LOAD) begin
      hid_r   <= in_location_id;
      hpop_r  <= in_population;
      hlast_r <= in_last_item;
    end
  end

  assign status.over_k    = (EW'(cnt_r) > k_eff);
  assign status.last_pend = hlast_r;
  assign status.one_left  = (cnt_r == CW'(1));

  assign out_id          = id_r[0];
  assign out_population  = pop_r[0];
  assign out_last_result = (cnt_r == CW'(1));

endmodule

// File: hdl/top_k_by_count_selector.sv
// Top level of the top-k-by-count selector: controller plus sorted cell chain.
// Depends on tkc_pkg, tkc_ctrl and tkc_datapath.
//
// Keeps the k records with the largest population out of a stream and, on the
// record marked last, emits them fewest-first (ties in arrival order) with the
// final beat flagged. On equal populations the earlier arrival is kept. Each
// record passes through accept, insert into the sorted chain and trim check, in
// the controller's sequence. When the insert leaves more than k records kept, the
// trim check drops the lowest one. After k was lowered, each surplus record is
// dropped before the insert. The last record then brings one output beat per kept
// record; beats are held while out_stall is high.
// k is clamped to 1..MAX_K and should be written only while the block is idle.
module top_k_by_count_selector #(
  parameter int MAX_K = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // record input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [tkc_pkg::DW-1:0] in_location_id,
  input  logic [tkc_pkg::DW-1:0] in_population,
  input  logic                   in_last_item,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [tkc_pkg::DW-1:0] out_id,
  output logic [tkc_pkg::DW-1:0] out_population,
  output logic                   out_last_result,
  // k register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [tkc_pkg::KW-1:0] cfg_k_count
);

  tkc_pkg::tkc_cmd_t    cmd;
  tkc_pkg::tkc_status_t status;

  assign cfg_ready = 1'b1;

  tkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tkc_datapath #(
    .MAX_K (MAX_K)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_k_count     (cfg_k_count),
    .in_location_id  (in_location_id),
    .in_population   (in_population),
    .in_last_item    (in_last_item),
    .out_id          (out_id),
    .out_population  (out_population),
    .out_last_result (out_last_result)
  );

endmodule

// File: sim/tb_top_k_by_count_selector.sv
// Self-checking testbench for top_k_by_count_selector: random and directed record sets.
// Depends on tkc_pkg and the top_k_by_count_selector RTL; a scoreboard class predicts
// the selected records.

module tb_top_k_by_count_selector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW          = tkc_pkg::DW;
  localparam int KW          = tkc_pkg::KW;
  localparam int MAX_K       = 16;
  localparam int ITEM_TARGET = 400;
  localparam int QUIET_AFTER = 330;
  localparam int SETTLE      = 48;
  localparam int LONG_HOLD   = 240;
  localparam int LIMIT       = 500000;

  typedef struct {
    logic [DW-1:0] id;
    logic [DW-1:0] pop;
    logic          last;
  } ranked_rec_t;

  // Tracks the kept records in ascending population order and queues the
  // records that each closing beat releases.
  class top_k_scoreboard;
    logic [KW-1:0] k_reg;
    logic [DW-1:0] kept_id[$];
    logic [DW-1:0] kept_pop[$];
    ranked_rec_t   emit_q[$];
    int            mismatches;

    function new();
      k_reg      = tkc_pkg::K_RESET;
      mismatches = 0;
    endfunction

    function void set_k(logic [KW-1:0] value);
      k_reg = value;
    endfunction

    // Zero behaves as one, anything past MAX_K as MAX_K
    function int k_limit();
      if (k_reg == 0) return 1;
      if (k_reg > MAX_K) return MAX_K;
      return int'(k_reg);
    endfunction

    // Drop the latest arrival among the lowest populations
    function void drop_lowest();
      int last_tie;
      last_tie = 0;
      while (last_tie + 1 < kept_pop.size() && kept_pop[last_tie + 1] == kept_pop[0])
        last_tie++;
      kept_id.delete(last_tie);
      kept_pop.delete(last_tie);
    endfunction

    function void note_record(logic [DW-1:0] id, logic [DW-1:0] pop, logic last);
      ranked_rec_t rec;
      int          lim;
      int          pos;
      lim = k_limit();
      pos = 0;
      while (kept_pop.size() > lim) drop_lowest();
      // Insert behind every entry of equal or lower population
      while (pos < kept_pop.size() && kept_pop[pos] <= pop) pos++;
      kept_id.insert(pos, id);
      kept_pop.insert(pos, pop);
      while (kept_pop.size() > lim) drop_lowest();
      if (last) begin
        foreach (kept_id[i]) begin
          rec.id   = kept_id[i];
          rec.pop  = kept_pop[i];
          rec.last = (i == kept_id.size() - 1);
          emit_q.insert(emit_q.size(), rec);
        end
        kept_id.delete();
        kept_pop.delete();
      end
    endfunction

    function int pending();
      return emit_q.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [DW-1:0] id, logic [DW-1:0] pop, logic last);
      ranked_rec_t want;
      if (emit_q.size() == 0) begin
        flag($sformatf("unexpected result beat: id=%h pop=%h last=%b", id, pop, last));
        return;
      end
      want = emit_q.pop_front();
      if (want.id !== id || want.pop !== pop || want.last !== last)
        flag($sformatf("result mismatch: expected id=%h pop=%h last=%b, got id=%h pop=%h last=%b",
                       want.id, want.pop, want.last, id, pop, last));
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [DW-1:0] in_location_id;
  logic [DW-1:0] in_population;
  logic          in_last_item;
  logic          out_valid;
  logic          out_stall;
  logic [DW-1:0] out_id;
  logic [DW-1:0] out_population;
  logic          out_last_result;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [KW-1:0] cfg_k_count;

  top_k_scoreboard sb = new();

  int items_sent    = 0;
  int cycle_count   = 0;
  bit quiet         = 1'b0;
  bit burst_mode    = 1'b0;
  bit long_hold_req = 1'b0;

  top_k_by_count_selector #(.MAX_K(MAX_K)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_location_id (in_location_id),
    .in_population  (in_population),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_id         (out_id),
    .out_population (out_population),
    .out_last_result(out_last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_k_count    (cfg_k_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_id, out_population, out_last_result);
  end

  // Stall the result side in random bursts; hold off on request; go quiet at the end
  initial begin
    out_stall <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // Offer one record beat, hold it until accepted, then maybe idle
  task automatic send_record(logic [DW-1:0] id, logic [DW-1:0] pop, logic last);
    in_valid       <= 1'b1;
    in_location_id <= id;
    in_population  <= pop;
    in_last_item   <= last;
    do @(posedge clk); while (in_stall);
    sb.note_record(id, pop, last);
    items_sent++;
    if (!quiet && !burst_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Pause the sender until every expected result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_k(logic [KW-1:0] value);
    cfg_valid   <= 1'b1;
    cfg_k_count <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_k(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_population(int unsigned mode);
    case (mode)
      0: return DW'($urandom_range(0, 7));
      1: return DW'(1000 + $urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return {{(DW-1){1'b1}}, 1'b0};
          default: return DW'(1);
        endcase
      end
      default: return DW'($urandom());
    endcase
  endfunction

  // Send a run of records; mark the final one last when closing the set
  task automatic send_set(int len, bit close);
    int unsigned mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < len; i++)
      send_record(DW'($urandom()), pick_population(mode), close && (i == len - 1));
  endtask

  function automatic logic [KW-1:0] pick_k();
    case ($urandom_range(0, 7))
      0: return KW'(0);
      1: return KW'(1);
      2: return KW'(16);
      3: return KW'(17);
      4: return '1;
      default: return KW'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic int pick_length();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 10);
    return $urandom_range(11, 24);
  endfunction

  initial begin
    int phase;
    in_valid       <= 1'b0;
    in_location_id <= '0;
    in_population  <= '0;
    in_last_item   <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_k_count    <= '0;
    rst_n          <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset k: fewer records than k, field extremes
    send_record('0, '1, 1'b0);
    send_record('1, '0, 1'b0);
    send_record(32'h1234_5678, 32'h8000_0000, 1'b0);
    send_record(32'hA5A5_A5A5, 32'h7FFF_FFFF, 1'b1);
    // Single-record set
    send_record(32'h5A5A_5A5A, '0, 1'b1);
    drain();

    // Zero k keeps one; the earlier of two equal counts wins
    write_k(KW'(0));
    send_record(32'd1, 32'd5, 1'b0);
    send_record(32'd2, 32'd5, 1'b0);
    send_record(32'd3, 32'd3, 1'b1);
    drain();

    // Ties at the cut keep the earlier arrivals
    write_k(KW'(2));
    send_record(32'd10, 32'd7, 1'b0);
    send_record(32'd11, 32'd7, 1'b0);
    send_record(32'd12, 32'd7, 1'b0);
    send_record(32'd13, 32'd2, 1'b0);
    send_record(32'd14, 32'd7, 1'b1);
    drain();

    // Lower k in the middle of a set
    write_k(KW'(4));
    send_record(32'd20, 32'd9, 1'b0);
    send_record(32'd21, 32'd1, 1'b0);
    send_record(32'd22, 32'd1, 1'b0);
    send_record(32'd23, 32'd5, 1'b0);
    drain();
    write_k(KW'(2));
    send_record(32'd24, 32'd0, 1'b1);

    // Random phases, each with its own k
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      write_k(pick_k());
      if (phase == 3) begin
        // Hold off the receiver while the sender keeps pushing
        long_hold_req = 1'b1;
        burst_mode    = 1'b1;
        send_set(6, 1'b1);
        send_set(10, 1'b1);
        send_set(3, 1'b1);
        burst_mode = 1'b0;
      end else if (phase % 5 == 4) begin
        send_set($urandom_range(4, 14), 1'b0);
        drain();
        write_k(KW'($urandom_range(0, 4)));
        send_set($urandom_range(1, 6), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) send_set(pick_length(), 1'b1);
      end
      phase++;
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
